@@ rtl/twts_pkg.sv @@
// ----------------------------------------------------------------------------
// twts_pkg: shared types and codes for the two-way time sync slave
// Transaction structs, operation and phase codes, stamp format constants.
// ----------------------------------------------------------------------------
`default_nettype none

package twts_pkg;

	// default number of 16-bit words in a stamp
	localparam int STAMP_WORDS_DEF = 4;

	// operation codes
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_SYNC_WR = 2'd1;
	localparam logic [1:0] OP_TIME_RD = 2'd2;
	localparam logic [1:0] OP_REQUEST = 2'd3;

	// exchange phase codes
	localparam logic [2:0] PH_IDLE        = 3'd0;
	localparam logic [2:0] PH_WAIT_HOST   = 3'd1;
	localparam logic [2:0] PH_WAIT_FOLLOW = 3'd2;
	localparam logic [2:0] PH_WAIT_DOUT   = 3'd3;
	localparam logic [2:0] PH_WAIT_DIN    = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] stamp;
	} twts_in_t;

	typedef struct packed {
		logic               offset_valid;
		logic signed [63:0] offset;
		logic [63:0]        clock_now;
		logic [2:0]         sync_phase;
		logic               request_flag;
	} twts_out_t;

endpackage

`default_nettype wire

@@ rtl/two_way_time_sync_slave.sv @@
// ----------------------------------------------------------------------------
// two_way_time_sync_slave: slave side of a two-way time sync exchange
// Keeps a local tick clock, captures t1/t1p/t2, and on the closing write
// applies offset = ((t1-t1p)-(t2-t2p))/2 (truncated toward zero).
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload    | one transaction
//  --------+----------------------+------------+-------------------------------
//  req     | req_valid/req_ready  | twts_in_t  | one operation with its stamp
//  rsp     | rsp_valid/rsp_ready  | twts_out_t | one result for each operation
//
//  one transaction per cycle unless rsp stalls; rsp_valid when req reaches result reg
//  the whole state update for an operation happens in the cycle it leaves
//  the input register, so back-to-back operations see each other's effects
//  arst_n clears the clock, the stamps, the phase and the request flag
//  a stalled rsp holds the result register; the input register still takes
//  one more transaction, then req_ready drops until rsp drains
//
`default_nettype none

module two_way_time_sync_slave
	import twts_pkg::*;
#(
	parameter int STAMP_WORDS = STAMP_WORDS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire twts_in_t  req_data,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output twts_out_t      rsp_data
);

	// stamp format: only the low STAMP_WORDS*16 bits are meaningful
	localparam int          STAMP_BITS = 16 * STAMP_WORDS;
	localparam logic [63:0] STAMP_MASK = {64{1'b1}} >> (64 - STAMP_BITS);

	// input register
	logic      in_valid_s1;
	twts_in_t  in_s1;

	// result register
	logic      out_valid_s2;
	twts_out_t out_s2;

	// exchange state
	logic [2:0]  phase_q;
	logic [63:0] clock_q;
	logic [63:0] t1p_q;      // local clock at the sync write
	logic [63:0] d1_q;       // t1 - t1p, formed once t1 is known
	logic [63:0] pre_q;      // (t1 - t1p) - t2, formed at the host read
	logic        request_q;

	// next-state values
	logic [2:0]  phase_d;
	logic [63:0] clock_d;
	logic [63:0] t1p_d;
	logic [63:0] d1_d;
	logic [63:0] pre_d;
	logic        request_d;
	logic        applied;
	logic [63:0] offset_d;

	logic [63:0] stamp_m;
	logic        present;
	logic [63:0] diff;
	logic        round_up;

	logic advance;

	// result register frees when empty or being taken
	assign advance   = !out_valid_s2 || rsp_ready;
	assign req_ready = !in_valid_s1 || advance;
	assign rsp_valid = out_valid_s2;
	assign rsp_data  = out_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			in_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			in_s1 <= req_data;
		end
	end

	// stamp decode
	assign stamp_m = in_s1.stamp & STAMP_MASK;
	assign present = stamp_m[STAMP_BITS-1 -: 16] != 16'd0;

	// closing write: diff = (t1-t1p) - (t2-t2p) = pre + t2p
	// halving toward zero adds one back for negative odd differences,
	// folded into the clock adder as a carry in
	assign diff     = pre_q + stamp_m;
	assign round_up = diff[63] & diff[0];

	always_comb begin
		phase_d   = phase_q;
		clock_d   = clock_q;
		t1p_d     = t1p_q;
		d1_d      = d1_q;
		pre_d     = pre_q;
		request_d = request_q;
		applied   = 1'b0;
		offset_d  = 64'd0;
		case (in_s1.operation)
			OP_TICK: begin
				clock_d = clock_q + 64'd1;
			end
			OP_SYNC_WR: begin
				if (phase_q inside {PH_IDLE, PH_WAIT_HOST}) begin
					// capture t1p; take t1 at once when it came along
					t1p_d = clock_q;
					if (present) begin
						d1_d    = stamp_m - clock_q;
						phase_d = PH_WAIT_DOUT;
					end else begin
						phase_d = PH_WAIT_FOLLOW;
					end
				end else if (phase_q == PH_WAIT_FOLLOW) begin
					// follow-up carries t1 whatever its top word
					d1_d    = stamp_m - t1p_q;
					phase_d = PH_WAIT_DOUT;
				end else if (phase_q == PH_WAIT_DIN) begin
					// t2p arrives: apply the correction
					offset_d  = {diff[63], diff[63:1]} + {63'd0, round_up};
					clock_d   = clock_q + {diff[63], diff[63:1]} + {63'd0, round_up};
					applied   = 1'b1;
					phase_d   = PH_IDLE;
					request_d = 1'b0;
				end
			end
			OP_TIME_RD: begin
				if (phase_q == PH_WAIT_DOUT) begin
					// t2 is the local clock now
					pre_d   = d1_q - clock_q;
					phase_d = PH_WAIT_DIN;
				end
			end
			default: begin
				// sync request, from any phase
				request_d = 1'b1;
				phase_d   = PH_WAIT_HOST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			clock_q   <= 64'd0;
			t1p_q     <= 64'd0;
			d1_q      <= 64'd0;
			pre_q     <= 64'd0;
			request_q <= 1'b0;
		end else if (in_valid_s1 && advance) begin
			phase_q   <= phase_d;
			clock_q   <= clock_d;
			t1p_q     <= t1p_d;
			d1_q      <= d1_d;
			pre_q     <= pre_d;
			request_q <= request_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid_s1 && advance) begin
			out_s2.offset_valid <= applied;
			out_s2.offset       <= offset_d;
			out_s2.clock_now    <= clock_d;
			out_s2.sync_phase   <= phase_d;
			out_s2.request_flag <= request_d;
		end
	end

`ifndef SYNTHESIS
	// an applied offset always closes the exchange
	a_applied_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && out_s2.offset_valid |->
			out_s2.sync_phase == PH_IDLE && !out_s2.request_flag)
		else $error("offset applied without closing the exchange");

	// no offset reported unless one was applied
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !out_s2.offset_valid |-> out_s2.offset == 64'd0)
		else $error("nonzero offset without offset_valid");

	// a held input moves into a free result register on the next edge
	a_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && advance |=> out_valid_s2)
		else $error("input transaction lost between stages");

	// reported state matches the live state right after an update
	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && advance |=>
			out_s2.clock_now == clock_q && out_s2.sync_phase == phase_q &&
			out_s2.request_flag == request_q)
		else $error("result disagrees with exchange state");

	// input side stalls only with both stages full and the output blocked
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> in_valid_s1 && out_valid_s2 && !rsp_ready)
		else $error("req_ready dropped without backpressure");
`endif

endmodule

`default_nettype wire
